/* src/qdd_pkg.sv */
// ============================================================================
// qdd_pkg - shared types and constants of the quadrature detent decoder
// Register codes, event codes, queue entry layout and the Gray-code step table.
// ============================================================================
package qdd_pkg;

   // Quadrature steps that make up one detent
   localparam int STEPS_PER_DETENT = 4;
   localparam int ACC_W            = 4;
   localparam int POS_W            = 32;
   localparam int COUNT_W          = 32;
   localparam int TIME_W           = 32;
   localparam int DEBOUNCE_W       = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int QUEUE_DEPTH      = 2;

   // Register reset values
   localparam logic signed [POS_W-1:0]   MIN_POSITION_RESET = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0]   MAX_POSITION_RESET = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [DEBOUNCE_W-1:0]     ROT_DEBOUNCE_RESET = DEBOUNCE_W'(5);
   localparam logic [DEBOUNCE_W-1:0]     BTN_DEBOUNCE_RESET = DEBOUNCE_W'(50);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_POSITION = 2'd0,
      CSR_MAX_POSITION = 2'd1,
      CSR_ROT_DEBOUNCE = 2'd2,
      CSR_BTN_DEBOUNCE = 2'd3
   } qdd_csr_index_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } qdd_dir_type;

   typedef enum logic {
      KIND_ROTATION = 1'b0,
      KIND_BUTTON   = 1'b1
   } qdd_kind_type;

   typedef struct packed {
      logic signed [POS_W-1:0] min_position;
      logic signed [POS_W-1:0] max_position;
      logic [DEBOUNCE_W-1:0]   rot_debounce_ms;
      logic [DEBOUNCE_W-1:0]   btn_debounce_ms;
   } qdd_cfg_type;

   // One classified request: up to one rotation and one button event
   typedef struct packed {
      logic                    rot_event;
      qdd_dir_type             rot_dir;
      logic signed [POS_W-1:0] position;
      logic                    btn_event;
      logic                    btn_pressed;
      logic [COUNT_W-1:0]      presses_before;
   } qdd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qdd_queue_status_type;

   // Step for a transition, indexed by {old A, old B, new A, new B}
   function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
      logic signed [1:0] step;
      unique case (idx) inside
         4'd1, 4'd7, 4'd8, 4'd14:  step = 2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: step = -2'sd1;
         default:                  step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

/* src/qdd_front.sv */
// ============================================================================
// qdd_front - request acceptance and classification
// Holds the decoder state, decodes quadrature and button changes per request
// and pushes the resulting events into the queue.
// ============================================================================
module qdd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  qdd_pkg::qdd_cfg_type            cfg,
   input  logic                            req_valid,
   input  logic [1:0]                      req_quad_levels,
   input  logic                            req_button_down,
   input  logic [qdd_pkg::TIME_W-1:0]      req_time_ms,
   input  qdd_pkg::qdd_queue_status_type   queue_status,
   output logic                            req_stall,
   output logic                            push,
   output qdd_pkg::qdd_entry_type          push_data
);

   localparam logic signed [qdd_pkg::ACC_W-1:0] DETENT =
      qdd_pkg::ACC_W'(qdd_pkg::STEPS_PER_DETENT);

   logic                                  primed_ff, primed_in;
   logic [1:0]                            last_quad_ff, last_quad_in;
   logic signed [qdd_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic signed [qdd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                                  btn_state_ff, btn_state_in;
   logic [qdd_pkg::COUNT_W-1:0]           presses_ff, presses_in;
   logic [qdd_pkg::TIME_W-1:0]            last_rot_ff, last_rot_in;
   logic [qdd_pkg::TIME_W-1:0]            last_btn_ff, last_btn_in;

   logic                                  accept;
   logic [qdd_pkg::TIME_W-1:0]            rot_elapsed, btn_elapsed;
   logic                                  rot_ok, btn_ok, cw, ccw;
   logic signed [1:0]                     step;
   logic signed [qdd_pkg::ACC_W-1:0]      acc_sum;
   logic signed [qdd_pkg::POS_W:0]        pos_wide;
   logic signed [qdd_pkg::POS_W:0]        min_wide, max_wide;
   logic signed [qdd_pkg::POS_W-1:0]      pos_clamped;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rot_elapsed = req_time_ms - last_rot_ff;
      btn_elapsed = req_time_ms - last_btn_ff;
      rot_ok = primed_ff && (req_quad_levels != last_quad_ff) &&
               (rot_elapsed >= {{(qdd_pkg::TIME_W-qdd_pkg::DEBOUNCE_W){1'b0}},
                                cfg.rot_debounce_ms});
      btn_ok = primed_ff && (req_button_down != btn_state_ff) &&
               (btn_elapsed >= {{(qdd_pkg::TIME_W-qdd_pkg::DEBOUNCE_W){1'b0}},
                                cfg.btn_debounce_ms});
      step    = qdd_pkg::gray_step({last_quad_ff, req_quad_levels});
      acc_sum = acc_ff + {{(qdd_pkg::ACC_W-2){step[1]}}, step};
      cw  = rot_ok && (step != 2'sd0) && (acc_sum >= DETENT);
      ccw = rot_ok && (step != 2'sd0) && (acc_sum <= -DETENT);

      // Move by one in a wider word, then clamp; the limits bound the range
      pos_wide = {pos_ff[qdd_pkg::POS_W-1], pos_ff} +
                 (cw ? (qdd_pkg::POS_W+1)'(1) : {(qdd_pkg::POS_W+1){1'b1}});
      min_wide = {cfg.min_position[qdd_pkg::POS_W-1], cfg.min_position};
      max_wide = {cfg.max_position[qdd_pkg::POS_W-1], cfg.max_position};
      if (pos_wide < min_wide) begin
         pos_clamped = cfg.min_position;
      end else if (pos_wide > max_wide) begin
         pos_clamped = cfg.max_position;
      end else begin
         pos_clamped = pos_wide[qdd_pkg::POS_W-1:0];
      end

      primed_in    = primed_ff;
      last_quad_in = last_quad_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      btn_state_in = btn_state_ff;
      presses_in   = presses_ff;
      last_rot_in  = last_rot_ff;
      last_btn_in  = last_btn_ff;

      if (accept) begin
         primed_in    = 1'b1;
         last_quad_in = req_quad_levels;
         if (!primed_ff) begin
            btn_state_in = req_button_down;
         end
         if (rot_ok) begin
            last_rot_in = req_time_ms;
            if (cw) begin
               acc_in = acc_sum - DETENT;
            end else if (ccw) begin
               acc_in = acc_sum + DETENT;
            end else begin
               acc_in = acc_sum;
            end
         end
         if (cw || ccw) begin
            pos_in = pos_clamped;
         end
         if (btn_ok) begin
            btn_state_in = req_button_down;
            last_btn_in  = req_time_ms;
            presses_in   = presses_ff + qdd_pkg::COUNT_W'(req_button_down);
         end
      end

      push                     = accept && (cw || ccw || btn_ok);
      push_data.rot_event      = cw || ccw;
      push_data.rot_dir        = cw ? qdd_pkg::DIR_CW :
                                 (ccw ? qdd_pkg::DIR_CCW : qdd_pkg::DIR_NONE);
      push_data.position       = (cw || ccw) ? pos_clamped : pos_ff;
      push_data.btn_event      = btn_ok;
      push_data.btn_pressed    = req_button_down;
      push_data.presses_before = presses_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         last_quad_ff <= 2'd0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         btn_state_ff <= 1'b0;
         presses_ff   <= '0;
         last_rot_ff  <= '0;
         last_btn_ff  <= '0;
      end else begin
         primed_ff    <= primed_in;
         last_quad_ff <= last_quad_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         btn_state_ff <= btn_state_in;
         presses_ff   <= presses_in;
         last_rot_ff  <= last_rot_in;
         last_btn_ff  <= last_btn_in;
      end
   end

   // The accumulator stays strictly inside one detent between requests
   assert property (@(posedge clock) disable iff (reset)
      (acc_ff < DETENT) && (acc_ff > -DETENT))
      else $error("detent accumulator left its range");

endmodule

/* src/qdd_fifo.sv */
// ============================================================================
// qdd_fifo - short event queue
// Register-based queue that decouples classification from result delivery.
// ============================================================================
module qdd_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  qdd_pkg::qdd_entry_type          push_data,
   input  logic                            pop,
   output qdd_pkg::qdd_entry_type          head,
   output qdd_pkg::qdd_queue_status_type   status
);

   localparam int PTR_W = (qdd_pkg::QUEUE_DEPTH > 1) ? $clog2(qdd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(qdd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(qdd_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(qdd_pkg::QUEUE_DEPTH);

   qdd_pkg::qdd_entry_type slots_ff [qdd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from an empty queue");

endmodule

/* src/qdd_back.sv */
// ============================================================================
// qdd_back - result delivery
// Expands each queue entry into one or two results and holds them in an
// output register until the receiver takes them.
// ============================================================================
module qdd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  qdd_pkg::qdd_entry_type          head,
   input  qdd_pkg::qdd_queue_status_type   queue_status,
   output logic                            pop,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic                            rsp_event_kind,
   output logic [1:0]                      rsp_direction,
   output logic signed [qdd_pkg::POS_W-1:0] rsp_position,
   output logic                            rsp_pressed,
   output logic [qdd_pkg::COUNT_W-1:0]     rsp_press_count,
   output logic                            rsp_last_of_run
);

   // Set once the rotation half of a two-result entry has gone out
   logic                             phase_ff, phase_in;
   logic                             valid_ff, valid_in;
   qdd_pkg::qdd_kind_type            kind_ff, kind_in;
   qdd_pkg::qdd_dir_type             dir_ff, dir_in;
   logic signed [qdd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                             pressed_ff, pressed_in;
   logic [qdd_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             last_ff, last_in;

   logic load, emit, emit_rot;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      emit     = load && !queue_status.empty;
      emit_rot = head.rot_event && !phase_ff;

      phase_in   = phase_ff;
      pop        = 1'b0;
      valid_in   = load ? emit : valid_ff;
      kind_in    = kind_ff;
      dir_in     = dir_ff;
      pos_in     = pos_ff;
      pressed_in = pressed_ff;
      count_in   = count_ff;
      last_in    = last_ff;

      if (emit) begin
         pos_in = head.position;
         if (emit_rot) begin
            kind_in    = qdd_pkg::KIND_ROTATION;
            dir_in     = head.rot_dir;
            pressed_in = 1'b0;
            count_in   = head.presses_before;
            last_in    = !head.btn_event;
            phase_in   = head.btn_event;
            pop        = !head.btn_event;
         end else begin
            kind_in    = qdd_pkg::KIND_BUTTON;
            dir_in     = qdd_pkg::DIR_NONE;
            pressed_in = head.btn_pressed;
            count_in   = head.presses_before + qdd_pkg::COUNT_W'(head.btn_pressed);
            last_in    = 1'b1;
            phase_in   = 1'b0;
            pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      dir_ff     <= dir_in;
      pos_ff     <= pos_in;
      pressed_ff <= pressed_in;
      count_ff   <= count_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_direction   = dir_ff;
   assign rsp_position    = pos_ff;
   assign rsp_pressed     = pressed_ff;
   assign rsp_press_count = count_ff;
   assign rsp_last_of_run = last_ff;

   // Mid-entry, the head must still be the entry with both events
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!queue_status.empty && head.rot_event && head.btn_event))
      else $error("split entry lost from queue head");

endmodule

/* src/quadrature_detent_decoder.sv */
// ============================================================================
// quadrature_detent_decoder - rotary encoder decoder with detent and button
// Decodes quadrature pin samples into detent events with a clamped position,
// and debounced push-switch changes into button events with a press count.
// ============================================================================
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  quad_levels, button_down, time_ms
//   rsp      out        rsp_valid/rsp_stall  event_kind, direction, position,
//                                            pressed, press_count, last_of_run
//   csr      in         csr_write_enable     csr_index, csr_data
//
// A request is classified in the cycle it is accepted; one request per cycle
// is taken while the event queue has room. Results leave the output register
// at one per cycle while rsp is not stalled, so a request causing two events
// yields two results; the output port sets the sustained rate when events
// are dense. A first result goes through a queue slot, then the output register.
// Reset is synchronous; registers return to their reset values, queue empties.
// A stall on rsp backs up the queue; req_stall rises only when it is full.
//
module quadrature_detent_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [qdd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [qdd_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_quad_levels,
   input  logic                                req_button_down,
   input  logic [qdd_pkg::TIME_W-1:0]          req_time_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_event_kind,
   output logic [1:0]                          rsp_direction,
   output logic signed [qdd_pkg::POS_W-1:0]    rsp_position,
   output logic                                rsp_pressed,
   output logic [qdd_pkg::COUNT_W-1:0]         rsp_press_count,
   output logic                                rsp_last_of_run
);

   qdd_pkg::qdd_cfg_type          cfg_ff, cfg_in;
   qdd_pkg::qdd_entry_type        push_data, head;
   qdd_pkg::qdd_queue_status_type queue_status;
   logic                          push, pop;

   // Register file: decode the index, drop the upper data bits of short fields
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (qdd_pkg::qdd_csr_index_type'(csr_index))
            qdd_pkg::CSR_MIN_POSITION: cfg_in.min_position = csr_data;
            qdd_pkg::CSR_MAX_POSITION: cfg_in.max_position = csr_data;
            qdd_pkg::CSR_ROT_DEBOUNCE:
               cfg_in.rot_debounce_ms = csr_data[qdd_pkg::DEBOUNCE_W-1:0];
            qdd_pkg::CSR_BTN_DEBOUNCE:
               cfg_in.btn_debounce_ms = csr_data[qdd_pkg::DEBOUNCE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_position    <= qdd_pkg::MIN_POSITION_RESET;
         cfg_ff.max_position    <= qdd_pkg::MAX_POSITION_RESET;
         cfg_ff.rot_debounce_ms <= qdd_pkg::ROT_DEBOUNCE_RESET;
         cfg_ff.btn_debounce_ms <= qdd_pkg::BTN_DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify requests and hold decoder state
   qdd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_quad_levels (req_quad_levels),
      .req_button_down (req_button_down),
      .req_time_ms     (req_time_ms),
      .queue_status    (queue_status),
      .req_stall       (req_stall),
      .push            (push),
      .push_data       (push_data)
   );

   // Decouple classification from delivery
   qdd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   // Expand entries into results
   qdd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .queue_status    (queue_status),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_direction   (rsp_direction),
      .rsp_position    (rsp_position),
      .rsp_pressed     (rsp_pressed),
      .rsp_press_count (rsp_press_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Only a rotation event can be followed by another result of the same request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (rsp_event_kind == qdd_pkg::KIND_ROTATION))
      else $error("button event not last of its request");

endmodule
